/* rtl/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;
  localparam int Capacity = 64;
  localparam int AddrW    = $clog2(Capacity);
  localparam int LenW     = $clog2(Capacity + 1);
  localparam int DataW    = 32;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    CMD_INS_POS = 3'd0,
    CMD_DEL_POS = 3'd1,
    CMD_SEARCH  = 3'd2,
    CMD_GET     = 3'd3,
    CMD_INS_TL  = 3'd4,
    CMD_DEL_HD  = 3'd5,
    CMD_NOP6    = 3'd6,
    CMD_NOP7    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [6:0]        position;
    logic [DataW-1:0]  value;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT_UP,
    BK_FETCH,
    BK_SHIFT_DN,
    BK_SEARCH,
    BK_DONE
  } bk_state_t;
endpackage

/* rtl/olist_ram.sv */
// ----------------------------------------------------------------------------
// olist_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olist_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/olist_front.sv */
// ----------------------------------------------------------------------------
// olist_front
// Accepts command items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module olist_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  olist_pkg::item_t    in_item,
  output logic                busy,
  output logic                q_valid,
  output olist_pkg::item_t    q_item,
  input  logic                q_pop
);
  import olist_pkg::*;

  item_t             buf_r [QDepth];
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic [QPtrW-1:0]  rd_r, wr_r;
  logic              push;

  assign busy    = (cnt_r == QCntW'(QDepth));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
      wr_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= (wr_r == QPtrW'(QDepth - 1)) ? '0 : wr_r + QPtrW'(1);
      end
      if (q_pop) begin
        rd_r <= (rd_r == QPtrW'(QDepth - 1)) ? '0 : rd_r + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r] <= in_item;
    end
  end
endmodule

/* rtl/olist_back.sv */
// ----------------------------------------------------------------------------
// olist_back
// Executes list commands against the entry RAM, one entry move per cycle.
// ----------------------------------------------------------------------------
module olist_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  olist_pkg::item_t               q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [olist_pkg::DataW-1:0]    out_read_value,
  output logic [olist_pkg::AddrW-1:0]    out_found_position,
  output logic [olist_pkg::LenW-1:0]     out_list_length
);
  import olist_pkg::*;

  bk_state_t          st_r, st_nxt;
  item_t              it_r;
  logic [LenW-1:0]    cnt_r, cnt_nxt;
  logic [LenW-1:0]    idx_r, idx_nxt;
  logic [LenW-1:0]    q_pos;
  logic [LenW-1:0]    tgt_w;
  status_t            stat_r, stat_nxt;
  logic [DataW-1:0]   rv_r, rv_nxt;
  logic [AddrW-1:0]   fp_r, fp_nxt;
  logic               up_last, next_end, shift_end, hit;

  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [DataW-1:0]   wdata, rdata;

  olist_ram #(.Width(DataW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign q_pop     = (st_r == BK_IDLE) && q_valid;
  assign q_pos     = LenW'(q_item.position);
  assign tgt_w     = (it_r.cmd == CMD_INS_TL) ? cnt_r : LenW'(it_r.position);
  assign up_last   = (idx_r == tgt_w);
  assign next_end  = ((idx_r + LenW'(1)) >= cnt_r);
  assign shift_end = ((idx_r + LenW'(2)) >= cnt_r);
  assign hit       = (rdata == it_r.value);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          st_nxt = BK_DONE;
          case (q_item.cmd)
            CMD_INS_POS: begin
              if (q_pos <= cnt_r && cnt_r != LenW'(Capacity)) begin
                st_nxt = BK_SHIFT_UP;
              end
            end
            CMD_INS_TL: begin
              if (cnt_r != LenW'(Capacity)) begin
                st_nxt = BK_SHIFT_UP;
              end
            end
            CMD_DEL_POS, CMD_GET: begin
              if (q_pos < cnt_r) begin
                st_nxt = BK_FETCH;
              end
            end
            CMD_DEL_HD: begin
              if (cnt_r != '0) begin
                st_nxt = BK_FETCH;
              end
            end
            CMD_SEARCH: begin
              if (cnt_r != '0) begin
                st_nxt = BK_SEARCH;
              end
            end
            default: st_nxt = BK_DONE;
          endcase
        end
      end
      BK_SHIFT_UP: begin
        if (up_last) begin
          st_nxt = BK_DONE;
        end
      end
      BK_FETCH: begin
        if (it_r.cmd == CMD_GET || next_end) begin
          st_nxt = BK_DONE;
        end else begin
          st_nxt = BK_SHIFT_DN;
        end
      end
      BK_SHIFT_DN: begin
        if (shift_end) begin
          st_nxt = BK_DONE;
        end
      end
      BK_SEARCH: begin
        if (hit || next_end) begin
          st_nxt = BK_DONE;
        end
      end
      BK_DONE: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // read data always belongs to the address issued in the previous cycle
  always_comb begin
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    stat_nxt = stat_r;
    rv_nxt   = rv_r;
    fp_nxt   = fp_r;
    we       = 1'b0;
    waddr    = idx_r[AddrW-1:0];
    wdata    = rdata;
    raddr    = idx_r[AddrW-1:0];
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          stat_nxt = ST_OK;
          rv_nxt   = '0;
          fp_nxt   = '0;
          case (q_item.cmd)
            CMD_INS_POS, CMD_INS_TL: begin
              idx_nxt = cnt_r;
              raddr   = AddrW'(cnt_r - LenW'(1));
              if (q_item.cmd == CMD_INS_POS && q_pos > cnt_r) begin
                stat_nxt = ST_RANGE;
              end else if (cnt_r == LenW'(Capacity)) begin
                stat_nxt = ST_FULL;
              end
            end
            CMD_DEL_POS, CMD_GET: begin
              idx_nxt = q_pos;
              raddr   = q_pos[AddrW-1:0];
              if (q_pos >= cnt_r) begin
                stat_nxt = ST_RANGE;
              end
            end
            CMD_DEL_HD: begin
              idx_nxt = '0;
              raddr   = '0;
              if (cnt_r == '0) begin
                stat_nxt = ST_MISSING;
              end
            end
            CMD_SEARCH: begin
              idx_nxt  = '0;
              raddr    = '0;
              stat_nxt = ST_MISSING;
            end
            default: ;
          endcase
        end
      end
      BK_SHIFT_UP: begin
        // rdata holds entry idx-1, moved up to idx
        we = 1'b1;
        if (up_last) begin
          wdata   = it_r.value;
          cnt_nxt = cnt_r + LenW'(1);
        end else begin
          idx_nxt = idx_r - LenW'(1);
          raddr   = AddrW'(idx_r - LenW'(2));
        end
      end
      BK_FETCH: begin
        rv_nxt = rdata;
        if (it_r.cmd != CMD_GET) begin
          if (next_end) begin
            cnt_nxt = cnt_r - LenW'(1);
          end else begin
            raddr = AddrW'(idx_r + LenW'(1));
          end
        end
      end
      BK_SHIFT_DN: begin
        // rdata holds entry idx+1, moved down to idx
        we = 1'b1;
        if (shift_end) begin
          cnt_nxt = cnt_r - LenW'(1);
        end else begin
          idx_nxt = idx_r + LenW'(1);
          raddr   = AddrW'(idx_r + LenW'(2));
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          stat_nxt = ST_OK;
          fp_nxt   = idx_r[AddrW-1:0];
        end else if (!next_end) begin
          idx_nxt = idx_r + LenW'(1);
          raddr   = AddrW'(idx_r + LenW'(1));
        end
      end
      BK_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      cnt_r  <= '0;
      idx_r  <= '0;
      stat_r <= ST_OK;
      rv_r   <= '0;
      fp_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      stat_r <= stat_nxt;
      rv_r   <= rv_nxt;
      fp_r   <= fp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r <= q_item;
    end
  end

  assign out_valid          = (st_r == BK_DONE);
  assign out_status         = stat_r;
  assign out_read_value     = rv_r;
  assign out_found_position = fp_r;
  assign out_list_length    = cnt_r;
endmodule

/* rtl/ordered_list_engine_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Positional list of signed words with insert, delete, search and get.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  command  | in_cmd, in_position, in_value           | start & !busy
//  result   | out_status, out_read_value,             | out_valid, one cycle
//           | out_found_position, out_list_length     |
// An accepted item passes through the queue to the back end. Insert moves
// each entry at or above the position up one slot, then writes the value;
// delete and get read the entry, then delete moves each later entry down;
// search compares entries in order. The one-write, one-read entry RAM with
// registered read sets this. Reset clears length and queue. Results cannot
// be stalled; busy rises only when the 2-item queue fills.
module ordered_list_engine_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_cmd,
  input  logic [6:0]                    in_position,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [31:0]            out_read_value,
  output logic [5:0]                    out_found_position,
  output logic [6:0]                    out_list_length
);
  import olist_pkg::*;

  item_t  in_item, q_item;
  logic   q_valid, q_pop;

  assign in_item.cmd      = cmd_t'(in_cmd);
  assign in_item.position = in_position;
  assign in_item.value    = in_value;

  olist_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  olist_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_status(out_status),
    .out_read_value(out_read_value), .out_found_position(out_found_position),
    .out_list_length(out_list_length)
  );
endmodule
